// ----- hw/rtl/fnvlp_pkg.sv -----
// ----------------------------------------------------------------------------
// fnvlp_pkg
// Shared constants, codes and types of the hashed key table.
// ----------------------------------------------------------------------------
`default_nettype none

package fnvlp_pkg;

    localparam int CAPACITY      = 64;
    localparam int SLOT_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int KEY_BYTES     = 31;
    localparam int MAX_KEY_BYTES = 31;
    localparam int KEY_BITS      = KEY_BYTES * 8;
    localparam int LEN_W         = 5;
    localparam int BYTE_IDX_W    = $clog2(KEY_BYTES);
    localparam int VALUE_W       = 32;
    localparam int HASH_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int SLOT_OUT_W    = 6;
    localparam int RESULT_W      = 32;

    localparam int IN_FIELDS_W   = LEN_W + KEY_BITS + VALUE_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = STATUS_W + SLOT_OUT_W + RESULT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD_LEN   = 3'd5
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [LEN_W-1:0]    len;
        logic [VALUE_W-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic            done;
        logic [HASH_W-1:0] hash;
    } t_hash_result;

endpackage

`default_nettype wire

// ----- hw/rtl/fnvlp_hash.sv -----
// ----------------------------------------------------------------------------
// fnvlp_hash
// Iterative 32-bit FNV-1a unit, one key byte per cycle on a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvlp_hash (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fnvlp_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [fnvlp_pkg::LEN_W-1:0]    i_len,
    output fnvlp_pkg::t_hash_result            o_result
);
    import fnvlp_pkg::*;

    logic [HASH_W-1:0]     r_h, n_h;
    logic [BYTE_IDX_W-1:0] r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [7:0]            w_byte;
    logic [HASH_W-1:0]     w_mix;
    logic                  w_last;

    assign w_byte = i_key[{r_cnt, 3'b000} +: 8];
    assign w_mix  = r_h ^ {{(HASH_W-8){1'b0}}, w_byte};
    assign w_last = (r_cnt == BYTE_IDX_W'(i_len - 1'b1));

    always_comb begin
        n_h    = r_h;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_h    = HASH_BASIS;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_h = HASH_W'(w_mix * HASH_PRIME);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_h   <= n_h;
        r_cnt <= n_cnt;
    end

    assign o_result.done = r_done;
    assign o_result.hash = r_h;

endmodule

`default_nettype wire

// ----- hw/rtl/fnvlp_store.sv -----
// ----------------------------------------------------------------------------
// fnvlp_store
// Slot storage for key, key length and value; one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvlp_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [fnvlp_pkg::SLOT_W-1:0] i_waddr,
    input  fnvlp_pkg::t_entry                i_wdata,
    input  wire logic [fnvlp_pkg::SLOT_W-1:0] i_raddr,
    output fnvlp_pkg::t_entry                o_rdata
);
    import fnvlp_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/fnv_linear_probe_key_table.sv -----
// ----------------------------------------------------------------------------
// fnv_linear_probe_key_table
// Key-value table with FNV-1a home slot and linear probing, set and get requests.
// ----------------------------------------------------------------------------
// One request at a time. A request with key_len L first runs its L key bytes
// through the shared FNV multiply step, then reads and compares each probed
// slot in separate states, S_RD and S_CMP, because the slot store has one read
// port with registered data. A bad key length goes straight to the result; a
// set into a full table is answered after hashing, with no probe. The next
// request is taken as soon as the result has moved into the output register,
// even while that result still waits. The table is empty after reset with
// no clearing pass; slots are tracked by valid flip-flops.
`default_nettype none

module fnv_linear_probe_key_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output      logic                             o_s_axis_tready,
    // key_len[4:0], key_word0[68:5], key_word1[132:69], key_word2[196:133],
    // key_word3[252:197], value[284:253], zero fill
    input  wire logic [fnvlp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  wire logic                             i_s_axis_tuser,
    output      logic                             o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // status[2:0], slot_index[8:3], result_value[40:9], zero fill
    output      logic [fnvlp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import fnvlp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HASH = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_op, n_op;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [SLOT_W-1:0]     r_probe, n_probe;
    logic [CAPACITY-1:0]   r_valid, n_valid;
    logic [CNT_W-1:0]      r_count, n_count;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [VALUE_W-1:0]    r_result, n_result;
    logic                  r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic                  w_accept;
    logic [LEN_W-1:0]      w_in_len;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [KEY_BITS-1:0]   w_trim_key;
    logic                  w_bad_len;
    logic                  w_hash_start;
    t_hash_result          w_hash;
    logic [SLOT_W-1:0]     w_home;
    logic                  w_we;
    t_entry                w_wentry;
    t_entry                w_rentry;
    logic                  w_slot_valid;
    logic                  w_match;
    logic [SLOT_W-1:0]     w_idx_inc;
    logic                  w_last_probe;
    logic                  w_out_free;

    assign w_in_len  = i_s_axis_tdata[LEN_W-1:0];
    assign w_in_key  = i_s_axis_tdata[LEN_W +: KEY_BITS];
    assign w_bad_len = (w_in_len == '0) || (32'(w_in_len) > MAX_KEY_BYTES);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_trim_key[b*8 +: 8] = (32'(w_in_len) > b) ? w_in_key[b*8 +: 8] : 8'h00;
        end
    end

    assign w_hash_start = w_accept && !w_bad_len;

    fnvlp_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_key    (n_key),
        .i_len    (n_len),
        .o_result (w_hash)
    );

    assign w_home = SLOT_W'(w_hash.hash % CAPACITY);

    assign w_wentry.key   = r_key;
    assign w_wentry.len   = r_len;
    assign w_wentry.value = r_value;

    fnvlp_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rentry)
    );

    assign w_slot_valid = r_valid[r_idx];
    assign w_match      = (w_rentry.len == r_len) && (w_rentry.key == r_key);
    assign w_idx_inc    = (r_idx == SLOT_W'(CAPACITY - 1)) ? '0 : r_idx + 1'b1;
    assign w_last_probe = (r_probe == SLOT_W'(CAPACITY - 1));
    assign w_we         = (r_state == S_CMP) && (r_op == OP_SET)
                          && (!w_slot_valid || w_match);
    assign w_out_free   = !r_m_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_len     = r_len;
        n_key     = r_key;
        n_value   = r_value;
        n_idx     = r_idx;
        n_probe   = r_probe;
        n_valid   = r_valid;
        n_count   = r_count;
        n_status  = r_status;
        n_slot    = r_slot;
        n_result  = r_result;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_s_axis_tuser;
                    n_len    = w_in_len;
                    n_key    = w_trim_key;
                    n_value  = i_s_axis_tdata[LEN_W + KEY_BITS +: VALUE_W];
                    n_slot   = '0;
                    n_result = '0;
                    if (w_bad_len) begin
                        n_status = ST_BAD_LEN;
                        n_state  = S_DONE;
                    end else begin
                        n_state  = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hash.done) begin
                    n_idx   = w_home;
                    n_probe = '0;
                    if ((r_op == OP_SET) && (r_count >= CNT_W'(CAPACITY))) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!w_slot_valid) begin
                    if (r_op == OP_SET) begin
                        n_valid[r_idx] = 1'b1;
                        n_count        = r_count + 1'b1;
                        n_status       = ST_INSERTED;
                        n_slot         = r_idx;
                    end else begin
                        n_status       = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else if (w_match) begin
                    n_slot = r_idx;
                    if (r_op == OP_SET) begin
                        n_status = ST_UPDATED;
                    end else begin
                        n_status = ST_FOUND;
                        n_result = w_rentry.value;
                    end
                    n_state = S_DONE;
                end else if (w_last_probe) begin
                    n_status = (r_op == OP_SET) ? ST_FULL : ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_probe = r_probe + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_TDATA_W'({RESULT_W'(r_result),
                                              SLOT_OUT_W'(r_slot), r_status});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_op     <= n_op;
        r_len    <= n_len;
        r_key    <= n_key;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_probe  <= n_probe;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_result <= n_result;
        r_m_data <= n_m_data;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("entry count does not match valid slots");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_op == OP_SET && !w_slot_valid)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise entry count");

    a_found_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[STATUS_W-1:0] == ST_FOUND)
        |-> r_valid[o_m_axis_tdata[STATUS_W +: SLOT_W]])
        else $error("found result points at an empty slot");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_m_valid && n_m_valid) |-> (r_state == S_DONE))
        else $error("result loaded outside completion state");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hashed key table: a directed table of set and
// get requests, then random requests drawn from a small key pool so that
// updates, collisions and probe chains occur, and later a larger pool that
// fills the table. Results are checked against a table predictor or typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import fnvlp_pkg::*;

    localparam int N_RANDOM   = 1980;
    localparam int CALM_ITEMS = 200;
    localparam int POOL_SIZE  = 128;
    localparam int WATCHDOG   = 5000;

    typedef struct packed {
        t_status                st;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [RESULT_W-1:0]    res;
    } t_reply;

    typedef struct {
        logic                 op;
        logic [LEN_W-1:0]     len;
        logic [KEY_BITS-1:0]  key;
        logic [VALUE_W-1:0]   value;
        bit                   typed;
        t_reply               rep;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]    s_data = '0;
    logic                     s_user = 1'b0;
    logic                     m_ready = 1'b0;
    wire logic                s_ready;
    wire logic                m_valid;
    wire logic [OUT_TDATA_W-1:0] m_data;

    // predictor copy of the table
    bit                       tab_valid [CAPACITY];
    logic [KEY_BITS-1:0]      tab_key   [CAPACITY];
    logic [LEN_W-1:0]         tab_len   [CAPACITY];
    logic [VALUE_W-1:0]       tab_value [CAPACITY];
    int                       entry_count = 0;

    t_reply                   expected_replies [$];
    t_row                     directed [$];
    logic [KEY_BITS-1:0]      pool_key [POOL_SIZE];
    logic [LEN_W-1:0]         pool_len [POOL_SIZE];

    bit                       calm = 1'b0;
    int                       errors = 0;
    int                       requests_sent = 0;
    int                       replies_seen = 0;
    int                       idle_cycles = 0;
    int                       status_seen [8];

    fnv_linear_probe_key_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [KEY_BITS-1:0] byte_mask(input logic [LEN_W-1:0] len);
        return (KEY_BITS'(1) << (8 * len)) - KEY_BITS'(1);
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_bytes();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) begin
            v[32*i +: 32] = $urandom;
        end
        return v[KEY_BITS-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return $urandom;
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return LEN_W'($urandom_range(1, 8));
        end else if (r < 85) begin
            return LEN_W'($urandom_range(9, 20));
        end
        return LEN_W'($urandom_range(21, MAX_KEY_BYTES));
    endfunction

    // fnv-1a home slot, then linear probe over the local table copy
    task automatic probe_table(input logic op, input logic [LEN_W-1:0] len,
                               input logic [KEY_BITS-1:0] raw_key,
                               input logic [VALUE_W-1:0] val, output t_reply rep);
        logic [KEY_BITS-1:0] key;
        logic [HASH_W-1:0]   h;
        int                  idx;
        rep = '{st: ST_FULL, slot: '0, res: '0};
        if (len == 0) begin
            rep.st = ST_BAD_LEN;
            return;
        end
        key = raw_key & byte_mask(len);
        h = HASH_BASIS;
        for (int b = 0; b < len; b++) begin
            h = (h ^ HASH_W'(key[8*b +: 8])) * HASH_PRIME;
        end
        idx = int'(h % CAPACITY);
        if (op == OP_SET) begin
            if (entry_count < CAPACITY) begin
                for (int n = 0; n < CAPACITY; n++) begin
                    if (!tab_valid[idx]) begin
                        tab_valid[idx] = 1'b1;
                        tab_key[idx]   = key;
                        tab_len[idx]   = len;
                        tab_value[idx] = val;
                        entry_count++;
                        rep = '{st: ST_INSERTED, slot: SLOT_OUT_W'(idx), res: '0};
                        break;
                    end
                    if (tab_len[idx] == len && tab_key[idx] == key) begin
                        tab_value[idx] = val;
                        rep = '{st: ST_UPDATED, slot: SLOT_OUT_W'(idx), res: '0};
                        break;
                    end
                    idx = (idx + 1) % CAPACITY;
                end
            end
        end else begin
            rep.st = ST_NOT_FOUND;
            for (int n = 0; n < CAPACITY; n++) begin
                if (!tab_valid[idx]) begin
                    break;
                end
                if (tab_len[idx] == len && tab_key[idx] == key) begin
                    rep = '{st: ST_FOUND, slot: SLOT_OUT_W'(idx), res: tab_value[idx]};
                    break;
                end
                idx = (idx + 1) % CAPACITY;
            end
        end
    endtask

    task automatic send_request(input t_row row);
        t_reply rep;
        int     gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= row.op;
        s_data  <= IN_TDATA_W'({row.value, row.key[KEY_BITS-1:0], row.len});
        do @(posedge i_clk); while (!s_ready);
        probe_table(row.op, row.len, row.key, row.value, rep);
        expected_replies.push_back(row.typed ? row.rep : rep);
        requests_sent++;
    endtask

    function automatic t_row mk_row(input logic op, input int len,
                                    input logic [KEY_BITS-1:0] key,
                                    input logic [VALUE_W-1:0] value);
        t_row r;
        r.op    = op;
        r.len   = LEN_W'(len);
        r.key   = key;
        r.value = value;
        r.typed = 1'b0;
        r.rep   = '{st: ST_INSERTED, slot: '0, res: '0};
        return r;
    endfunction

    function automatic t_row mk_typed(input logic op, input int len,
                                      input logic [KEY_BITS-1:0] key, input t_status st);
        t_row r;
        r = mk_row(op, len, key, '1);
        r.typed = 1'b1;
        r.rep   = '{st: st, slot: '0, res: '0};
        return r;
    endfunction

    // response side stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        t_reply got;
        got = '{st: t_status'(m_data[2:0]), slot: m_data[8:3], res: m_data[40:9]};
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_valid && m_ready) begin
                replies_seen++;
                status_seen[m_data[2:0]]++;
                if (expected_replies.size() == 0) begin
                    $error("unexpected reply: status %0d slot %0d value %h",
                           got.st, got.slot, got.res);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.st !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, got.st);
                        errors++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.res !== want.res) begin
                        $error("result_value: expected %h, actual %h", want.res, got.res);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG) @(posedge i_clk);
        $display("watchdog: no request or reply for %0d cycles", WATCHDOG);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [KEY_BITS-1:0] ones;
        logic [KEY_BITS-1:0] raw;
        t_row                row;
        int                  r;
        int                  j;
        int                  pool_lim;
        ones = '1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        directed.push_back(mk_typed(OP_GET, 3, KEY_BITS'(24'h636261), ST_NOT_FOUND));
        directed.push_back(mk_typed(OP_SET, 0, ones, ST_BAD_LEN));
        directed.push_back(mk_typed(OP_GET, 0, ones, ST_BAD_LEN));
        directed.push_back(mk_row(OP_SET, 1, '0, '0));
        directed.push_back(mk_row(OP_SET, 31, ones, '1));
        directed.push_back(mk_row(OP_GET, 31, ones, '0));
        directed.push_back(mk_row(OP_GET, 30, ones, '0));
        directed.push_back(mk_row(OP_SET, 30, ones, 32'h1234_5678));
        directed.push_back(mk_row(OP_GET, 30, ones, '1));
        directed.push_back(mk_row(OP_SET, 1, {ones[KEY_BITS-1:8], 8'h00}, '1));
        directed.push_back(mk_row(OP_GET, 1, '0, '0));
        directed.push_back(mk_row(OP_GET, 2, '0, '0));
        directed.push_back(mk_row(OP_SET, 1, KEY_BITS'(8'hff), 32'h0000_0001));
        directed.push_back(mk_row(OP_SET, 8, ones, 32'ha5a5_a5a5));
        directed.push_back(mk_row(OP_SET, 9, ones, 32'h5a5a_5a5a));
        directed.push_back(mk_row(OP_SET, 24, ones, 32'h0f0f_0f0f));
        directed.push_back(mk_row(OP_SET, 25, ones, 32'hf0f0_f0f0));
        directed.push_back(mk_row(OP_GET, 8, ones, '0));
        directed.push_back(mk_row(OP_GET, 9, ones, '0));
        directed.push_back(mk_row(OP_GET, 24, ones, '0));
        directed.push_back(mk_row(OP_GET, 25, ones, '0));
        directed.push_back(mk_row(OP_SET, 31, ones, '0));
        directed.push_back(mk_row(OP_GET, 31, ones, '1));
        directed.push_back(mk_row(OP_GET, 1, KEY_BITS'(8'hff), '0));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end

        // key pool, some entries are prefixes or extensions of earlier ones
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = rand_len();
            if (i > 0 && $urandom_range(0, 4) == 0) begin
                j = $urandom_range(0, i - 1);
                raw = pool_key[j] | (rand_bytes() & ~byte_mask(pool_len[j]));
                pool_key[i] = raw & byte_mask(pool_len[i]);
            end else begin
                pool_key[i] = rand_bytes() & byte_mask(pool_len[i]);
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= N_RANDOM - CALM_ITEMS);
            pool_lim = (i < 900) ? 40 : POOL_SIZE;
            r = $urandom_range(0, 99);
            j = $urandom_range(0, pool_lim - 1);
            row = mk_row(1'($urandom_range(0, 1)), int'(pool_len[j]), pool_key[j],
                         rand_value());
            if (r < 3) begin
                row.len = '0;
                row.key = rand_bytes();
            end else if (r < 10) begin
                row.op  = OP_GET;
                row.len = LEN_W'($urandom_range(1, MAX_KEY_BYTES));
                row.key = rand_bytes();
            end else begin
                row.op = (r < 50) ? OP_SET : OP_GET;
                // junk above the key length must not matter
                if ($urandom_range(0, 1) == 1) begin
                    row.key = row.key | (rand_bytes() & ~byte_mask(row.len));
                end
            end
            send_request(row);
        end
        @(negedge i_clk);
        s_valid <= 1'b0;

        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d requests and %0d replies, table holds %0d of %0d slots",
                 requests_sent, replies_seen, entry_count, CAPACITY);
        $display("inserted %0d, updated %0d, found %0d, not found %0d, full %0d, bad length %0d",
                 status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL], status_seen[ST_BAD_LEN]);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
